// ===== sv/hrm_pkg.sv =====
// ---------------------------------------------------------------------------
// hrm_pkg: shared types and constants for the hard-rod Metropolis block
// Field widths, action and register codes, chain transaction structs.
// ---------------------------------------------------------------------------
package hrm_pkg;

    // Fixed field widths
    localparam int FB     = 24;   // fraction bits of a position
    localparam int RW     = 23;   // radius width
    localparam int IW     = 8;    // rod index field width
    localparam int PCW    = 9;    // point_count register width
    localparam int CNTW   = 24;   // step and success counters
    localparam int PRODW  = RW + FB;

    localparam int MAX_RODS_DEF = 256;

    localparam logic [FB-1:0] HALF = {1'b1, {(FB-1){1'b0}}};
    localparam logic [FB:0]   ONE  = {1'b1, {FB{1'b0}}};

    // Input actions
    localparam logic [1:0] A_LOAD  = 2'd0;
    localparam logic [1:0] A_TRIAL = 2'd1;
    localparam logic [1:0] A_READ  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_STEP_LIMIT  = 1'b1;

    // Data that travels from cell to cell
    typedef struct packed {
        logic [FB-1:0] x;
        logic [RW-1:0] r;
        logic          hit;
    } t_probe;

    // Query broadcast to every cell during a pass
    typedef struct packed {
        logic          check;   // 0: fetch target entry, 1: overlap check
        logic [FB-1:0] xn;
        logic [RW-1:0] rr;
    } t_query;

    // Entry write broadcast to every cell
    typedef struct packed {
        logic          en;
        logic          pos_only;
        logic [FB-1:0] x;
        logic [RW-1:0] r;
    } t_cwr;

endpackage

// ===== sv/hrm_if.sv =====
// ---------------------------------------------------------------------------
// hrm_if: channel interfaces of the hard-rod Metropolis block
// Input item channel, result channel and configuration write channel.
// ---------------------------------------------------------------------------
interface hrm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  rod_index;
    logic [23:0] position_in;
    logic [22:0] radius_in;
    logic [23:0] random_draw;

    modport source (output valid, action, rod_index, position_in, radius_in, random_draw,
                    input ready);
    modport sink   (input valid, action, rod_index, position_in, radius_in, random_draw,
                    output ready);
endinterface

interface hrm_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  moved_rod;
    logic        accepted;
    logic [23:0] position_out;
    logic [23:0] success_count;
    logic [23:0] step_count;
    logic        finished;

    modport source (output valid, moved_rod, accepted, position_out, success_count,
                    step_count, finished, input ready);
    modport sink   (input valid, moved_rod, accepted, position_out, success_count,
                    step_count, finished, output ready);
endinterface

interface hrm_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/hrm_cell.sv =====
// ---------------------------------------------------------------------------
// hrm_cell: one rod entry of the chain
// Holds a rod's centre and radius; on each cycle either picks its entry
// into the passing probe or folds its overlap test into the probe's hit flag.
// ---------------------------------------------------------------------------
module hrm_cell
    import hrm_pkg::*;
#(
    parameter int IDX = 0,
    parameter int NIW = 8,
    parameter int NCW = 9
) (
    input  logic           i_clk,
    input  t_probe         i_probe,
    output t_probe         o_probe,
    input  t_query         i_query,
    input  logic [NIW-1:0] i_tgt,
    input  logic [NCW-1:0] i_n,
    input  t_cwr           i_wr,
    input  logic [NIW-1:0] i_wr_idx
);

    logic [FB-1:0] r_pos;
    logic [RW-1:0] r_rad;
    t_probe        r_probe;
    t_probe        n_probe;

    logic          is_tgt;
    logic          in_use;
    logic [FB-1:0] sep;
    logic [FB-1:0] reach;

    assign is_tgt = (i_tgt == NIW'(IDX));
    assign in_use = (32'(IDX) < 32'(i_n)) && !is_tgt;
    assign sep    = (i_query.xn > r_pos) ? (i_query.xn - r_pos) : (r_pos - i_query.xn);
    assign reach  = FB'(i_query.rr) + FB'(r_rad);

    // Probe update
    always_comb begin
        n_probe = i_probe;
        if (!i_query.check) begin
            if (is_tgt) begin
                n_probe.x = r_pos;
                n_probe.r = r_rad;
            end
        end else begin
            n_probe.hit = i_probe.hit | (in_use && (sep < reach));
        end
    end

    // Entry storage and probe register
    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
        if (i_wr.en && (i_wr_idx == NIW'(IDX))) begin
            r_pos <= i_wr.x;
            if (!i_wr.pos_only) begin
                r_rad <= i_wr.r;
            end
        end
    end

    assign o_probe = r_probe;

endmodule

// ===== sv/hrm_chain.sv =====
// ---------------------------------------------------------------------------
// hrm_chain: row of rod cells
// A probe enters the first cell and is registered in each cell on its way to the last.
// ---------------------------------------------------------------------------
module hrm_chain
    import hrm_pkg::*;
#(
    parameter int MAX_RODS = MAX_RODS_DEF,
    parameter int NIW      = $clog2(MAX_RODS),
    parameter int NCW      = $clog2(MAX_RODS + 1)
) (
    input  logic           i_clk,
    input  t_query         i_query,
    input  logic [NIW-1:0] i_tgt,
    input  logic [NCW-1:0] i_n,
    input  t_cwr           i_wr,
    input  logic [NIW-1:0] i_wr_idx,
    output t_probe         o_probe
);

    t_probe probe [0:MAX_RODS];

    assign probe[0] = '0;

    for (genvar j = 0; j < MAX_RODS; j++) begin : g_cell
        hrm_cell #(
            .IDX (j),
            .NIW (NIW),
            .NCW (NCW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_probe  (probe[j]),
            .o_probe  (probe[j+1]),
            .i_query  (i_query),
            .i_tgt    (i_tgt),
            .i_n      (i_n),
            .i_wr     (i_wr),
            .i_wr_idx (i_wr_idx)
        );
    end

    assign o_probe = probe[MAX_RODS];

endmodule

// ===== sv/hrm_mod.sv =====
// ---------------------------------------------------------------------------
// hrm_mod: step counter modulo rod count
// Restoring remainder, one dividend bit per cycle.
// ---------------------------------------------------------------------------
module hrm_mod
    import hrm_pkg::*;
#(
    parameter int NIW = 8,
    parameter int NCW = 9
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [CNTW-1:0] i_dividend,
    input  logic [NCW-1:0]  i_divisor,
    output logic            o_done,
    output logic [NIW-1:0]  o_rem
);

    logic                    r_busy;
    logic                    r_done;
    logic [$clog2(CNTW)-1:0] r_bit;
    logic [CNTW-1:0]         r_dvd;
    logic [NCW-1:0]          r_div;
    logic [NCW-1:0]          r_rem;
    logic [NCW:0]            trial;
    logic [NCW:0]            n_rem;

    // One restoring step
    always_comb begin
        trial = {r_rem, r_dvd[CNTW-1]};
        n_rem = (trial >= {1'b0, r_div}) ? (trial - {1'b0, r_div}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_bit == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_bit <= $bits(r_bit)'(CNTW - 1);
        end else if (r_busy) begin
            r_rem <= n_rem[NCW-1:0];
            r_dvd <= {r_dvd[CNTW-2:0], 1'b0};
            r_bit <= r_bit - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[NIW-1:0];

endmodule

// ===== sv/metropolis_hard_rod_mixed_radius.sv =====
// ---------------------------------------------------------------------------
// metropolis_hard_rod_mixed_radius: Metropolis move for hard rods on [0,1)
// Each rod lives in a cell of a chain. A load writes its cell directly. A read
// of an index below MAX_RODS sends a fetch probe down the chain and emits the
// entry that it brings back. A trial picks the rod (step count modulo rod count),
// fetches it with one chain pass, does the move arithmetic, checks for overlap
// with a second pass and emits; once the step limit is reached it emits an empty
// result instead. A draw that lands out of bounds ends after the move arithmetic
// with no result. Items are taken one at a time; a result waits in the output
// register while the next item is accepted.
// ---------------------------------------------------------------------------
module metropolis_hard_rod_mixed_radius
    import hrm_pkg::*;
#(
    parameter int MAX_RODS = MAX_RODS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    hrm_in_if.sink     i_in,
    hrm_out_if.source  o_out,
    hrm_cfg_if.sink    i_cfg
);

    localparam int NIW = $clog2(MAX_RODS);
    localparam int NCW = $clog2(MAX_RODS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_PASS = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [PCW-1:0]   r_pc;
    logic [CNTW-1:0]  r_limit;
    logic [CNTW-1:0]  r_steps, n_steps;
    logic [CNTW-1:0]  r_succ, n_succ;
    logic [NCW-1:0]   r_cnt, n_cnt;
    logic             r_check, n_check;
    logic             r_trial, n_trial;
    logic [NIW-1:0]   r_tgt, n_tgt;
    logic [FB-1:0]    r_u, n_u;
    logic [FB-1:0]    r_x, n_x;
    logic [RW-1:0]    r_r, n_r;
    logic [PRODW-1:0] r_prod, n_prod;
    logic [FB-1:0]    r_xn, n_xn;
    logic [IW-1:0]    r_res_rod, n_res_rod;
    logic             r_res_acc, n_res_acc;
    logic [FB-1:0]    r_res_pos, n_res_pos;

    logic             r_out_valid;
    logic [IW-1:0]    r_out_rod;
    logic             r_out_acc;
    logic [FB-1:0]    r_out_pos;
    logic [CNTW-1:0]  r_out_succ;
    logic [CNTW-1:0]  r_out_steps;
    logic             r_out_fin;

    logic             in_acc;
    logic             idx_ok;
    logic             done_all;
    logic [NCW-1:0]   n_act;
    logic             mod_start;
    logic             mod_done;
    logic [NIW-1:0]   mod_rem;
    logic             emit_go;
    logic             mag_neg;
    logic [FB-1:0]    mag;
    logic [FB-1:0]    q;
    logic [FB:0]      xn_wide;
    logic             xn_ok;
    t_query           query;
    t_cwr             cwr;
    logic [NIW-1:0]   cwr_idx;
    t_probe           chain_out;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign idx_ok      = (32'(i_in.rod_index) < 32'(MAX_RODS));
    assign done_all    = (r_steps >= r_limit);
    assign emit_go     = !r_out_valid || o_out.ready;

    // Rods in use, clamped to 1 .. MAX_RODS
    always_comb begin
        if (r_pc == '0) begin
            n_act = NCW'(1);
        end else if (32'(r_pc) > 32'(MAX_RODS)) begin
            n_act = NCW'(MAX_RODS);
        end else begin
            n_act = NCW'(r_pc);
        end
    end

    // Displacement magnitude and candidate position
    assign mag_neg = (r_u < HALF);
    assign mag     = mag_neg ? (HALF - r_u) : (r_u - HALF);
    assign q       = r_prod[PRODW-1:FB-1];
    always_comb begin
        if (mag_neg) begin
            xn_wide = {1'b0, r_x} - {1'b0, q};
            xn_ok   = (q <= r_x);
        end else begin
            xn_wide = {1'b0, r_x} + {1'b0, q};
            xn_ok   = 1'b1;
        end
        xn_ok = xn_ok && (xn_wide > (FB+1)'(r_r)) && (xn_wide < (ONE - (FB+1)'(r_r)));
    end

    assign query.check = r_check;
    assign query.xn    = r_xn;
    assign query.rr    = r_r;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_steps   = r_steps;
        n_succ    = r_succ;
        n_cnt     = r_cnt;
        n_check   = r_check;
        n_trial   = r_trial;
        n_tgt     = r_tgt;
        n_u       = r_u;
        n_x       = r_x;
        n_r       = r_r;
        n_prod    = r_prod;
        n_xn      = r_xn;
        n_res_rod = r_res_rod;
        n_res_acc = r_res_acc;
        n_res_pos = r_res_pos;
        mod_start = 1'b0;
        cwr       = '0;
        cwr_idx   = NIW'(i_in.rod_index);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.action)
                        A_LOAD: begin
                            cwr.en       = idx_ok;
                            cwr.pos_only = 1'b0;
                            cwr.x        = i_in.position_in;
                            cwr.r        = i_in.radius_in;
                        end
                        A_READ: begin
                            n_res_rod = i_in.rod_index;
                            n_res_acc = 1'b0;
                            n_res_pos = '0;
                            n_trial   = 1'b0;
                            n_check   = 1'b0;
                            n_tgt     = NIW'(i_in.rod_index);
                            n_cnt     = '0;
                            n_state   = idx_ok ? S_PASS : S_EMIT;
                        end
                        A_TRIAL: begin
                            if (done_all) begin
                                n_res_rod = '0;
                                n_res_acc = 1'b0;
                                n_res_pos = '0;
                                n_state   = S_EMIT;
                            end else begin
                                n_u       = i_in.random_draw;
                                n_trial   = 1'b1;
                                mod_start = 1'b1;
                                n_state   = S_MOD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_tgt   = mod_rem;
                    n_check = 1'b0;
                    n_cnt   = '0;
                    n_state = S_PASS;
                end
            end
            S_PASS: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == NCW'(MAX_RODS)) begin
                    if (!r_check) begin
                        n_x       = chain_out.x;
                        n_r       = chain_out.r;
                        n_res_pos = chain_out.x;
                        n_state   = r_trial ? S_MUL : S_EMIT;
                    end else begin
                        cwr.en       = !chain_out.hit;
                        cwr.pos_only = 1'b1;
                        cwr.x        = r_xn;
                        cwr_idx      = r_tgt;
                        n_succ       = r_succ + CNTW'(!chain_out.hit);
                        n_steps      = r_steps + 1'b1;
                        n_res_rod    = IW'(r_tgt);
                        n_res_acc    = !chain_out.hit;
                        n_res_pos    = chain_out.hit ? r_x : r_xn;
                        n_state      = S_EMIT;
                    end
                end
            end
            S_MUL: begin
                n_prod  = PRODW'(r_r) * PRODW'(mag);
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (xn_ok) begin
                    n_xn    = xn_wide[FB-1:0];
                    n_check = 1'b1;
                    n_cnt   = '0;
                    n_state = S_PASS;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= PCW'(1);
            r_limit     <= '0;
            r_steps     <= '0;
            r_succ      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_steps <= n_steps;
            r_succ  <= n_succ;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_POINT_COUNT: r_pc    <= i_cfg.data[PCW-1:0];
                    CFG_STEP_LIMIT:  r_limit <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            if (r_state == S_EMIT && emit_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_cnt     <= n_cnt;
        r_check   <= n_check;
        r_trial   <= n_trial;
        r_tgt     <= n_tgt;
        r_u       <= n_u;
        r_x       <= n_x;
        r_r       <= n_r;
        r_prod    <= n_prod;
        r_xn      <= n_xn;
        r_res_rod <= n_res_rod;
        r_res_acc <= n_res_acc;
        r_res_pos <= n_res_pos;
        if (r_state == S_EMIT && emit_go) begin
            r_out_rod   <= r_res_rod;
            r_out_acc   <= r_res_acc;
            r_out_pos   <= r_res_pos;
            r_out_succ  <= r_succ;
            r_out_steps <= r_steps;
            r_out_fin   <= done_all;
        end
    end

    hrm_mod #(
        .NIW (NIW),
        .NCW (NCW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_steps),
        .i_divisor  (n_act),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    hrm_chain #(
        .MAX_RODS (MAX_RODS),
        .NIW      (NIW),
        .NCW      (NCW)
    ) u_chain (
        .i_clk    (i_clk),
        .i_query  (query),
        .i_tgt    (r_tgt),
        .i_n      (n_act),
        .i_wr     (cwr),
        .i_wr_idx (cwr_idx),
        .o_probe  (chain_out)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.moved_rod     = r_out_rod;
    assign o_out.accepted      = r_out_acc;
    assign o_out.position_out  = r_out_pos;
    assign o_out.success_count = r_out_succ;
    assign o_out.step_count    = r_out_steps;
    assign o_out.finished      = r_out_fin;

`ifndef SYNTH
    // Pass counter never runs beyond the chain length
    a_pass_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS) |-> (32'(r_cnt) <= 32'(MAX_RODS)))
        else $error("chain pass counter overran");

    // Accepted moves never exceed completed steps
    a_succ_le_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_succ <= r_steps)
        else $error("success count above step count");

    // Selected rod lies among the rods in use
    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && mod_done) |-> (32'(mod_rem) < 32'(n_act)))
        else $error("rod selection out of range");
`endif

endmodule

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// tb: testbench for the hard-rod Metropolis move block
// Loads rod layouts, runs trial draws, reads and unused actions through
// several rod counts and step limits. An independent model of the block
// predicts every result, and each result is checked field by field in order.
// The run also mixes in random gaps on both channels and one long output stall.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hrm_pkg::*;

    localparam logic [1:0] A_UNUSED = 2'd3;
    localparam int TABLE_SIZE = 256;
    localparam int DRAIN_CYCLES = 2 * TABLE_SIZE + 90;

    typedef struct {
        logic [1:0]  action;
        logic [7:0]  rod_index;
        logic [23:0] position_in;
        logic [22:0] radius_in;
        logic [23:0] random_draw;
    } rod_item_t;

    typedef struct packed {
        logic [7:0]  moved_rod;
        logic        accepted;
        logic [23:0] position_out;
        logic [23:0] success_count;
        logic [23:0] step_count;
        logic        finished;
    } rod_result_t;

    // Model of the rod table and counters; holds expected results in order
    class hard_rod_predictor;
        logic [23:0] positions [TABLE_SIZE];
        logic [22:0] radii [TABLE_SIZE];
        logic [23:0] trial_steps;
        logic [23:0] accepted_moves;
        logic [8:0]  point_count;
        logic [23:0] trial_cap;
        rod_result_t expected_results [$];
        int mismatches;
        int checked;
        int accepted_total;
        int finished_total;

        function new();
            trial_steps = '0;
            accepted_moves = '0;
            point_count = 9'd1;
            trial_cap = '0;
            mismatches = 0;
            checked = 0;
            accepted_total = 0;
            finished_total = 0;
            foreach (positions[k]) begin
                positions[k] = '0;
                radii[k] = '0;
            end
        endfunction

        function void write_register(logic idx, logic [23:0] data);
            if (idx == CFG_POINT_COUNT) point_count = data[8:0];
            else trial_cap = data;
        endfunction

        function void push_result(logic [7:0] rod, logic acc, logic [23:0] pos);
            rod_result_t r;
            r.moved_rod = rod;
            r.accepted = acc;
            r.position_out = pos;
            r.success_count = accepted_moves;
            r.step_count = trial_steps;
            r.finished = (trial_steps >= trial_cap);
            expected_results.push_back(r);
        endfunction

        // Work out what an accepted transaction does
        function void note_input(rod_item_t t);
            int n, i;
            logic [22:0] r;
            logic [23:0] x, mag;
            logic [46:0] prod;
            logic [24:0] q, xn, d;
            logic neg, ok;
            case (t.action)
                A_LOAD: begin
                    positions[t.rod_index] = t.position_in;
                    radii[t.rod_index] = t.radius_in;
                end
                A_READ: push_result(t.rod_index, 1'b0, positions[t.rod_index]);
                A_TRIAL: begin
                    if (trial_steps >= trial_cap) begin
                        push_result(8'd0, 1'b0, 24'd0);
                        return;
                    end
                    n = (point_count == 0) ? 1 :
                        (point_count > TABLE_SIZE) ? TABLE_SIZE : int'(point_count);
                    i = int'(trial_steps) % n;
                    r = radii[i];
                    x = positions[i];
                    neg = t.random_draw < HALF;
                    mag = neg ? HALF - t.random_draw : t.random_draw - HALF;
                    prod = r * mag;
                    q = prod >> (FB - 1);
                    if (neg) begin
                        if (q > x) return;
                        xn = x - q;
                    end else begin
                        xn = x + q;
                    end
                    // out-of-bounds candidate: no step, no result
                    if (!(xn > r && xn < ONE - r)) return;
                    ok = 1'b1;
                    for (int k = 0; k < n; k++) begin
                        if (k == i) continue;
                        d = (xn > positions[k]) ? xn - positions[k] : positions[k] - xn;
                        if (d < r + radii[k]) begin
                            ok = 1'b0;
                            break;
                        end
                    end
                    if (ok) begin
                        positions[i] = xn[23:0];
                        accepted_moves = accepted_moves + 1'b1;
                    end
                    trial_steps = trial_steps + 1'b1;
                    push_result(8'(i), ok, positions[i]);
                end
                default: ;
            endcase
        endfunction

        function void check_result(rod_result_t got);
            rod_result_t e;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result rod=%0d pos=%h", got.moved_rod,
                             got.position_out);
                return;
            end
            e = expected_results.pop_front();
            checked++;
            if (got.accepted === 1'b1) accepted_total++;
            if (got.finished === 1'b1) finished_total++;
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: exp rod=%0d acc=%0b pos=%h succ=%0d step=%0d fin=%0b,",
                              " got rod=%0d acc=%0b pos=%h succ=%0d step=%0d fin=%0b"},
                             e.moved_rod, e.accepted, e.position_out, e.success_count,
                             e.step_count, e.finished, got.moved_rod, got.accepted,
                             got.position_out, got.success_count, got.step_count,
                             got.finished);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    hrm_in_if  in_ch ();
    hrm_out_if out_ch ();
    hrm_cfg_if cfg_ch ();

    metropolis_hard_rod_mixed_radius dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    hard_rod_predictor rod_model = new();
    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int items_sent;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    initial begin
        #60ms;
        $display("FAILURE");
        $finish;
    end

    // Result side: check accepted results, then choose ready for the next edge
    initial begin
        rod_result_t got;
        out_ch.ready = 1'b0;
        hold_served = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.moved_rod = out_ch.moved_rod;
                got.accepted = out_ch.accepted;
                got.position_out = out_ch.position_out;
                got.success_count = out_ch.success_count;
                got.step_count = out_ch.step_count;
                got.finished = out_ch.finished;
                rod_model.check_result(got);
            end
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = 3000;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(rod_item_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= t.action;
        in_ch.rod_index <= t.rod_index;
        in_ch.position_in <= t.position_in;
        in_ch.radius_in <= t.radius_in;
        in_ch.random_draw <= t.random_draw;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        rod_model.note_input(t);
        items_sent++;
    endtask

    task automatic send_fields(logic [1:0] act, logic [7:0] idx, logic [23:0] pos,
                               logic [22:0] rad, logic [23:0] u);
        rod_item_t t;
        t.action = act;
        t.rod_index = idx;
        t.position_in = pos;
        t.radius_in = rad;
        t.random_draw = u;
        send_item(t);
    endtask

    // Drop valid, wait for every expected result, then let a slow trial finish
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (rod_model.expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [23:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        rod_model.write_register(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Spread rods 0..n-1 evenly; radii up to about 0.3 of the gap so some collide
    task automatic load_layout(int n);
        logic [24:0] gap, pos;
        gap = 25'(ONE / n);
        for (int k = 0; k < n; k++) begin
            pos = gap * k + gap / 2;
            send_fields(A_LOAD, 8'(k), pos[23:0], 23'($urandom_range(0, int'(gap) * 3 / 10)),
                        24'd0);
        end
    endtask

    task automatic random_item(int n);
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            send_fields(A_TRIAL, 8'($urandom), 24'($urandom), 23'($urandom), 24'($urandom));
        else if (pick < 90)
            send_fields(A_READ, 8'($urandom), 24'($urandom), 23'($urandom), 24'($urandom));
        else if (pick < 95)
            send_fields(A_LOAD, 8'($urandom_range(0, n - 1)), 24'($urandom),
                        23'($urandom_range(0, 24'hFFFFFF / (4 * n))), 24'($urandom));
        else
            send_fields(A_UNUSED, 8'($urandom), 24'($urandom), 23'($urandom),
                        24'($urandom));
    endtask

    initial begin
        int counts [10] = '{1, 0, 2, 3, 8, 256, 5, 511, 300, 16};
        int n;
        int budget;
        items_sent = 0;
        hold_requests = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.action = A_LOAD;
        in_ch.rod_index = '0;
        in_ch.position_in = '0;
        in_ch.radius_in = '0;
        in_ch.random_draw = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_POINT_COUNT;
        cfg_ch.data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole table first so no unwritten entry is ever read
        load_layout(TABLE_SIZE);

        // Directed: finished trials under the reset limit, reads, unused action
        send_fields(A_TRIAL, 8'd0, 24'd0, 23'd0, 24'h123456);
        send_fields(A_READ, 8'd0, 24'd0, 23'd0, 24'd0);
        send_fields(A_READ, 8'd255, 24'hFFFFFF, 23'h7FFFFF, 24'hFFFFFF);
        send_fields(A_UNUSED, 8'd7, 24'hFFFFFF, 23'h7FFFFF, 24'hFFFFFF);
        send_fields(A_LOAD, 8'd255, 24'hFFFFFF, 23'h7FFFFF, 24'd0);
        send_fields(A_READ, 8'd255, 24'd0, 23'd0, 24'd0);
        send_fields(A_LOAD, 8'd255, 24'hC00000, 23'd0, 24'd0);
        send_fields(A_LOAD, 8'd0, 24'h800000, 23'h100000, 24'd0);
        wait_idle();
        write_register(CFG_STEP_LIMIT, 24'hFFFFFF);
        // single rod: extreme draws, midpoint draw, left and right edges
        send_fields(A_TRIAL, 8'd0, 24'd0, 23'd0, 24'd0);
        send_fields(A_TRIAL, 8'd0, 24'd0, 23'd0, HALF);
        send_fields(A_TRIAL, 8'd0, 24'd0, 23'd0, 24'hFFFFFF);
        send_fields(A_TRIAL, 8'd0, 24'd0, 23'd0, HALF - 1);
        send_fields(A_LOAD, 8'd0, 24'h000010, 23'h00000F, 24'd0);
        send_fields(A_TRIAL, 8'd0, 24'd0, 23'd0, 24'd0);
        send_fields(A_TRIAL, 8'd0, 24'd0, 23'd0, 24'hFFFFFF);
        send_fields(A_LOAD, 8'd0, 24'hFFFFF0, 23'h00000F, 24'd0);
        send_fields(A_TRIAL, 8'd0, 24'd0, 23'd0, 24'hFFFFFF);
        send_fields(A_READ, 8'd0, 24'd0, 23'd0, 24'd0);
        wait_idle();
        // two touching rods: moves toward the neighbour collide
        write_register(CFG_POINT_COUNT, 24'd2);
        send_fields(A_LOAD, 8'd0, 24'h400000, 23'h200000, 24'd0);
        send_fields(A_LOAD, 8'd1, 24'h800000, 23'h200000, 24'd0);
        send_fields(A_TRIAL, 8'd0, 24'd0, 23'd0, 24'hFFFFFF);
        send_fields(A_TRIAL, 8'd0, 24'd0, 23'd0, 24'd0);

        // Random phases over rod counts, step limits and idling patterns
        for (int ph = 0; ph < 12; ph++) begin
            wait_idle();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            n = counts[ph % 10];
            write_register(CFG_POINT_COUNT, 24'(n));
            if (ph == 3)
                write_register(CFG_STEP_LIMIT, 24'd0);
            else if (ph == 6)
                write_register(CFG_STEP_LIMIT, rod_model.trial_steps + 24'd10);
            else
                write_register(CFG_STEP_LIMIT, 24'hFFFFFF);
            n = (n == 0) ? 1 : (n > TABLE_SIZE) ? TABLE_SIZE : n;
            // large counts keep whatever the table already holds
            if (n < 64) load_layout(n);
            budget = (n >= 256) ? 15 : 35;
            if (ph == 2) hold_requests++;
            for (int j = 0; j < budget; j++) begin
                if (ph == 4 && j == budget / 2) wait_idle();
                random_item(n);
            end
        end

        wait_idle();
        $display("Covered %0d transactions in, %0d results checked, %0d moves accepted,",
                 items_sent, rod_model.checked, rod_model.accepted_total);
        $display("%0d finished-state results, rod counts 0 to 511, limits 0 to max.",
                 rod_model.finished_total);
        if (rod_model.mismatches == 0 && rod_model.expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", rod_model.mismatches);
            $display("FAILURE");
        end
        $finish;
    end
endmodule
